@@ src/sprt_pkg.sv @@
package sprt_pkg;

    localparam int ONES_W  = 16;
    localparam int INDEX_W = 16;
    localparam int SLOPE_W = 17;
    localparam int ICPT_W  = 32;
    localparam int HELD_W  = ONES_W + 16;
    localparam int PROD_W  = INDEX_W + SLOPE_W;
    // Margin lines and their lookahead increments stay below 2^35 in magnitude.
    localparam int ACC_W   = 36;
    localparam int STEPS_W = 6;
    localparam int STEPS_MAX = 63;
    localparam int ONE_Q16 = 65536;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE           = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_INTERCEPT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_INTERCEPT = 2'd2;

    localparam logic [SLOPE_W-1:0] SLOPE_RESET           = 17'd32768;
    localparam logic [ICPT_W-1:0]  UPPER_INTERCEPT_RESET = 32'sd196608;
    localparam logic [ICPT_W-1:0]  LOWER_INTERCEPT_RESET = -32'sd196608;

    typedef enum logic [1:0] {
        DEC_CONTINUE,
        DEC_UPPER,
        DEC_LOWER
    } decision_t;

endpackage

@@ src/sprt_threshold_decision_core.sv @@
// Sequential probability ratio test decision for Bernoulli trials.
// Each transaction on the slave stream carries a count of ones and a trial
// index. The block compares the count with an upper and a lower straight line
// in Q16.16 and reports continue, above the upper line or below the lower line.
// It also scans the current trial and up to LOOKAHEAD - 1 further trials and
// reports the fewest trials before a crossing becomes possible, together with
// a found flag. The slope and both intercepts are set through the write port
// and must be written only while no transaction is in flight; the block does
// not enforce this. A write with an unused index is ignored. The pipeline has
// LOOKAHEAD + 3 register stages: an input stage, a multiply stage for index
// times slope, a margin stage and one stage for each lookahead trial. New
// transactions are taken in every cycle, one result per cycle, unless stalled.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds and s_axis_tready drops in the same cycle; nothing is lost
// or repeated. Reset empties the pipeline and restores the register defaults
// (slope one half, intercepts plus and minus three).
module sprt_threshold_decision_core #(
    parameter int LOOKAHEAD = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sprt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sprt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: ones_count[15:0], trial_index[31:16].
    input  logic [31:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: decision[1:0], steps_needed[7:2], steps_found[8], zero fill.
    output logic [15:0]                     m_axis_tdata
);
    import sprt_pkg::*;

    logic [SLOPE_W-1:0] slope_reg;
    logic [ICPT_W-1:0]  upper_icpt_reg;
    logic [ICPT_W-1:0]  lower_icpt_reg;

    logic advance;
    logic in_vld_reg;
    logic mul_vld_reg;
    logic [LOOKAHEAD:0] s_vld_reg;

    logic [ONES_W-1:0]  ones_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [HELD_W-1:0]  held_reg;
    logic [HELD_W-1:0]  held_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;

    logic signed [ACC_W-1:0] acc_u_reg  [LOOKAHEAD+1];
    logic signed [ACC_W-1:0] acc_l_reg  [LOOKAHEAD+1];
    logic signed [ACC_W-1:0] acc_u_next [LOOKAHEAD+1];
    logic signed [ACC_W-1:0] acc_l_next [LOOKAHEAD+1];
    logic                    found_reg  [LOOKAHEAD+1];
    logic                    found_next [LOOKAHEAD+1];
    logic [STEPS_W-1:0]      steps_reg  [LOOKAHEAD+1];
    logic [STEPS_W-1:0]      steps_next [LOOKAHEAD+1];
    decision_t               dec_reg    [LOOKAHEAD+1];
    decision_t               dec_next;

    logic signed [ACC_W-1:0] up_step;
    logic signed [ACC_W-1:0] slope_ext;
    logic signed [ACC_W-1:0] held_ext;
    logic signed [ACC_W-1:0] prod_ext;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = s_vld_reg[LOOKAHEAD];
    assign m_axis_tdata  = {7'd0, found_reg[LOOKAHEAD], steps_reg[LOOKAHEAD],
                            dec_reg[LOOKAHEAD]};

    assign slope_ext = $signed({{(ACC_W-SLOPE_W){1'b0}}, slope_reg});
    assign up_step   = $signed(ACC_W'(ONE_Q16)) - slope_ext;
    assign held_ext  = $signed({{(ACC_W-HELD_W){1'b0}}, held_reg});
    assign prod_ext  = $signed({{(ACC_W-PROD_W){1'b0}}, prod_reg});
    assign held_next = {ones_reg, 16'd0};
    assign prod_next = PROD_W'(idx_reg) * PROD_W'(slope_reg);

    always_comb
    begin
        acc_u_next[0] = held_ext - prod_ext
                      - $signed({{(ACC_W-ICPT_W){upper_icpt_reg[ICPT_W-1]}}, upper_icpt_reg});
        acc_l_next[0] = held_ext - prod_ext
                      - $signed({{(ACC_W-ICPT_W){lower_icpt_reg[ICPT_W-1]}}, lower_icpt_reg});
        found_next[0] = 1'b0;
        steps_next[0] = '0;
        if (!acc_u_next[0][ACC_W-1] && (acc_u_next[0] != '0))
        begin
            dec_next = DEC_UPPER;
        end
        else if (acc_l_next[0][ACC_W-1])
        begin
            dec_next = DEC_LOWER;
        end
        else
        begin
            dec_next = DEC_CONTINUE;
        end

        // Stage j tests lookahead trial j, then moves both margins on by one trial.
        for (int j = 0; j < LOOKAHEAD; j++)
        begin
            acc_u_next[j+1] = acc_u_reg[j] + up_step;
            acc_l_next[j+1] = acc_l_reg[j] - slope_ext;
            if (found_reg[j])
            begin
                found_next[j+1] = 1'b1;
                steps_next[j+1] = steps_reg[j];
            end
            else if ((!acc_u_reg[j][ACC_W-1] && (acc_u_reg[j] != '0)) ||
                     acc_l_reg[j][ACC_W-1])
            begin
                found_next[j+1] = 1'b1;
                steps_next[j+1] = STEPS_W'((j > STEPS_MAX) ? STEPS_MAX : j);
            end
            else
            begin
                found_next[j+1] = 1'b0;
                steps_next[j+1] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg      <= SLOPE_RESET;
            upper_icpt_reg <= UPPER_INTERCEPT_RESET;
            lower_icpt_reg <= LOWER_INTERCEPT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLOPE:           slope_reg      <= cfg_wdata[SLOPE_W-1:0];
                REG_UPPER_INTERCEPT: upper_icpt_reg <= cfg_wdata[ICPT_W-1:0];
                REG_LOWER_INTERCEPT: lower_icpt_reg <= cfg_wdata[ICPT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            s_vld_reg   <= '0;
        end
        else if (advance)
        begin
            in_vld_reg  <= s_axis_tvalid;
            mul_vld_reg <= in_vld_reg;
            s_vld_reg   <= {s_vld_reg[LOOKAHEAD-1:0], mul_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ones_reg   <= s_axis_tdata[15:0];
            idx_reg    <= s_axis_tdata[31:16];
            held_reg   <= held_next;
            prod_reg   <= prod_next;
            dec_reg[0] <= dec_next;
            for (int j = 0; j <= LOOKAHEAD; j++)
            begin
                acc_u_reg[j] <= acc_u_next[j];
                acc_l_reg[j] <= acc_l_next[j];
                found_reg[j] <= found_next[j];
                steps_reg[j] <= steps_next[j];
            end
            for (int j = 1; j <= LOOKAHEAD; j++)
            begin
                dec_reg[j] <= dec_reg[j-1];
            end
        end
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_vld_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s_vld_reg) && $stable(in_vld_reg) && $stable(mul_vld_reg))
        else $error("pipeline moved during a stall");

    a_crossing_now: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != DEC_CONTINUE)
        |-> m_axis_tdata[8] && (m_axis_tdata[7:2] == '0))
        else $error("current crossing not reported as zero steps found");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[8] |-> (m_axis_tdata[7:2] == '0))
        else $error("step count set without a crossing");

endmodule
